// ----- design/ipdc_pkg.sv -----
// Shared types and constants for the incremental PID controller with dead band and clamp.
`default_nettype none

package ipdc_pkg;

    // Fixed field widths of the register set and the result word.
    localparam int GAIN_W      = 24;
    localparam int LIMIT_W     = 47;
    localparam int BAND_W      = 17;
    localparam int DRIVE_W     = 38;

    // The clamped accumulator is scaled down by a power of two.
    localparam int SCALE_SHIFT = 10;
    localparam int SCALE_DIV   = 1 << SCALE_SHIFT;

    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = LIMIT_W;
    localparam int OUT_TDATA_W = ((DRIVE_W + 7) / 8) * 8;

    // Register indexes on the configuration port.
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_K1      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_K2      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_K3      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_OUTPUT_LIMIT = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_DEAD_BAND    = 3'd4;

    typedef struct packed {
        logic signed [GAIN_W-1:0] k1;
        logic signed [GAIN_W-1:0] k2;
        logic signed [GAIN_W-1:0] k3;
        logic [LIMIT_W-1:0]       limit;
        logic [BAND_W-1:0]        band;
    } t_cfg;

endpackage

`default_nettype wire

// ----- design/ipdc_cfg.sv -----
// Configuration register file: gains, output limit and dead band.
`default_nettype none

module ipdc_cfg
    import ipdc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_GAIN_K1:      r_cfg.k1    <= $signed(i_cfg_data[GAIN_W-1:0]);
                REG_GAIN_K2:      r_cfg.k2    <= $signed(i_cfg_data[GAIN_W-1:0]);
                REG_GAIN_K3:      r_cfg.k3    <= $signed(i_cfg_data[GAIN_W-1:0]);
                REG_OUTPUT_LIMIT: r_cfg.limit <= i_cfg_data[LIMIT_W-1:0];
                REG_DEAD_BAND:    r_cfg.band  <= i_cfg_data[BAND_W-1:0];
                default: begin
                    // Writes to unmapped indexes are dropped.
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- design/ipdc_clamp.sv -----
// Symmetric clamp of the accumulator and scaling by 1024 with truncation toward zero.
`default_nettype none

module ipdc_clamp
    import ipdc_pkg::*;
#(
    parameter int ACC_WIDTH = 48
) (
    input  wire logic signed [ACC_WIDTH-1:0] i_acc,
    input  wire logic        [LIMIT_W-1:0]   i_limit,
    output logic signed      [DRIVE_W-1:0]   o_drive
);

    localparam int CLW = ((ACC_WIDTH > LIMIT_W) ? ACC_WIDTH : LIMIT_W) + 1;

    logic signed [CLW-1:0] w_val;
    logic signed [CLW-1:0] w_lim;
    logic signed [CLW-1:0] w_nlim;
    logic signed [CLW-1:0] w_clip;
    logic signed [CLW-1:0] w_bias;
    logic signed [CLW-1:0] w_quot;

    assign w_val  = CLW'(i_acc);
    assign w_lim  = $signed(CLW'(i_limit));
    assign w_nlim = -w_lim;

    always_comb begin
        if (w_val > w_lim) begin
            w_clip = w_lim;
        end else if (w_val < w_nlim) begin
            w_clip = w_nlim;
        end else begin
            w_clip = w_val;
        end
    end

    // Adding divisor minus one to negative values turns the arithmetic shift
    // into a division that truncates toward zero.
    assign w_bias  = w_clip + (w_clip[CLW-1] ? CLW'(SCALE_DIV - 1) : CLW'(0));
    assign w_quot  = w_bias >>> SCALE_SHIFT;
    assign o_drive = $signed(w_quot[DRIVE_W-1:0]);

endmodule

`default_nettype wire

// ----- design/incremental_pid_deadband_clamp_top.sv -----
// Top level of the incremental PID controller with dead band and output clamp.
//
// Input words arrive on the s_axis channel, each holding a setpoint and a
// measured sample; every accepted word produces exactly one drive word on the
// m_axis channel, in order. The error is measured minus setpoint. Outside the
// dead band the accumulator grows by k1*e - k2*e[n-1] + k3*e[n-2] and
// saturates at its own width; inside it the accumulator is cleared. The drive
// is the accumulator clamped to +/- output_limit, divided by 1024 toward zero.
// The datapath has five register stages: input/error, products, product sum,
// accumulator, output. An accepted word is registered in each of them in turn
// before it is offered on m_axis. One word per cycle is sustained while m_axis
// accepts; the accumulator update feeding back on itself sets that rate.
// Each stage moves on whenever the stage after it is empty or moving, so the
// input stays ready while a result waits, until all five stages are full.
// A stalled receiver then holds the output word and back-pressures s_axis. Reset
// (synchronous, active low) empties the pipeline and clears the accumulator, the
// error history and all configuration registers. Registers are written through
// i_cfg_we/i_cfg_addr/i_cfg_data only while the block is idle; the user, not the block, ensures it.
`default_nettype none

module incremental_pid_deadband_clamp_top
    import ipdc_pkg::*;
#(
    parameter int ACC_WIDTH    = 48,
    parameter int SAMPLE_WIDTH = 16,
    localparam int IN_TDATA_W  = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // Fields from bit 0 up: setpoint, measured.
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // Fields from bit 0 up: drive.
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

    localparam int EW   = SAMPLE_WIDTH + 1;
    localparam int PW   = GAIN_W + EW;
    localparam int SUMW = PW + 2;
    localparam int WW   = ((ACC_WIDTH > SUMW) ? ACC_WIDTH : SUMW) + 1;
    localparam int CMPW = (EW > BAND_W) ? EW : BAND_W;

    localparam logic signed [WW-1:0] ACC_MAX_W = WW'({1'b0, {(ACC_WIDTH-1){1'b1}}});
    localparam logic signed [WW-1:0] ACC_MIN_W = ~ACC_MAX_W;

    t_cfg w_cfg;

    ipdc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // Stage handshake.
    logic r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld, r_s5_vld;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5;
    logic w_go1, w_go2, w_go3, w_go4, w_go5;

    assign w_rdy5 = !r_s5_vld || m_axis_tready;
    assign w_go5  = r_s4_vld && w_rdy5;
    assign w_rdy4 = !r_s4_vld || w_go5;
    assign w_go4  = r_s3_vld && w_rdy4;
    assign w_rdy3 = !r_s3_vld || w_go4;
    assign w_go3  = r_s2_vld && w_rdy3;
    assign w_rdy2 = !r_s2_vld || w_go3;
    assign w_go2  = r_s1_vld && w_rdy2;
    assign w_rdy1 = !r_s1_vld || w_go2;
    assign w_go1  = s_axis_tvalid && w_rdy1;

    assign s_axis_tready = w_rdy1;
    assign m_axis_tvalid = r_s5_vld;

    // Stage 1: error and dead band test.
    logic signed [SAMPLE_WIDTH-1:0] w_sp;
    logic signed [SAMPLE_WIDTH-1:0] w_ms;
    logic signed [EW-1:0]           n_err;
    logic [EW-1:0]                  w_mag;
    logic                           n_out;

    assign w_sp  = $signed(s_axis_tdata[SAMPLE_WIDTH-1:0]);
    assign w_ms  = $signed(s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]);
    assign n_err = EW'(w_ms) - EW'(w_sp);
    assign w_mag = n_err[EW-1] ? $unsigned(-n_err) : $unsigned(n_err);
    assign n_out = CMPW'(w_mag) > CMPW'(w_cfg.band);

    logic signed [EW-1:0] r_s1_err;
    logic                 r_s1_out;

    // Error history, shifted as each word leaves stage 1.
    logic signed [EW-1:0] r_err_last;
    logic signed [EW-1:0] r_err_prev;

    // Stage 2: the three gain products.
    logic signed [PW-1:0] n_p1, n_p2, n_p3;
    logic signed [PW-1:0] r_p1, r_p2, r_p3;
    logic                 r_s2_out;

    assign n_p1 = PW'(w_cfg.k1) * PW'(r_s1_err);
    assign n_p2 = PW'(w_cfg.k2) * PW'(r_err_last);
    assign n_p3 = PW'(w_cfg.k3) * PW'(r_err_prev);

    // Stage 3: increment.
    logic signed [SUMW-1:0] n_sum;
    logic signed [SUMW-1:0] r_sum;
    logic                   r_s3_out;

    assign n_sum = SUMW'(r_p1) - SUMW'(r_p2) + SUMW'(r_p3);

    // Stage 4: saturating accumulator.
    logic signed [WW-1:0]        w_wide;
    logic signed [ACC_WIDTH-1:0] n_acc;
    logic signed [ACC_WIDTH-1:0] r_acc;

    assign w_wide = WW'(r_acc) + WW'(r_sum);

    always_comb begin
        if (!r_s3_out) begin
            n_acc = '0;
        end else if (w_wide > ACC_MAX_W) begin
            n_acc = {1'b0, {(ACC_WIDTH-1){1'b1}}};
        end else if (w_wide < ACC_MIN_W) begin
            n_acc = {1'b1, {(ACC_WIDTH-1){1'b0}}};
        end else begin
            n_acc = w_wide[ACC_WIDTH-1:0];
        end
    end

    // Stage 5: clamp, scale and output register.
    logic signed [DRIVE_W-1:0] n_drive;
    logic signed [DRIVE_W-1:0] r_drive;

    ipdc_clamp #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_clamp (
        .i_acc   (r_acc),
        .i_limit (w_cfg.limit),
        .o_drive (n_drive)
    );

    assign m_axis_tdata = OUT_TDATA_W'($unsigned(r_drive));

    // Control and controller state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld   <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_s3_vld   <= 1'b0;
            r_s4_vld   <= 1'b0;
            r_s5_vld   <= 1'b0;
            r_err_last <= '0;
            r_err_prev <= '0;
            r_acc      <= '0;
        end else begin
            if (w_go1) begin
                r_s1_vld <= 1'b1;
            end else if (w_go2) begin
                r_s1_vld <= 1'b0;
            end
            if (w_go2) begin
                r_s2_vld   <= 1'b1;
                r_err_prev <= r_err_last;
                r_err_last <= r_s1_err;
            end else if (w_go3) begin
                r_s2_vld <= 1'b0;
            end
            if (w_go3) begin
                r_s3_vld <= 1'b1;
            end else if (w_go4) begin
                r_s3_vld <= 1'b0;
            end
            if (w_go4) begin
                r_s4_vld <= 1'b1;
                r_acc    <= n_acc;
            end else if (w_go5) begin
                r_s4_vld <= 1'b0;
            end
            if (w_go5) begin
                r_s5_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_s5_vld <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_go1) begin
            r_s1_err <= n_err;
            r_s1_out <= n_out;
        end
        if (w_go2) begin
            r_p1     <= n_p1;
            r_p2     <= n_p2;
            r_p3     <= n_p3;
            r_s2_out <= r_s1_out;
        end
        if (w_go3) begin
            r_sum    <= n_sum;
            r_s3_out <= r_s2_out;
        end
        if (w_go5) begin
            r_drive <= n_drive;
        end
    end

`ifndef SYNTH
    // A word inside the dead band leaves a cleared accumulator.
    a_band_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_go4 && !r_s3_out |=> r_acc == '0)
        else $error("accumulator not cleared for a word inside the dead band");

    // The older history entry takes the newer one when a word moves on.
    a_hist_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_go2 |=> r_err_prev == $past(r_err_last) && r_err_last == $past(r_s1_err))
        else $error("error history did not shift");

    // A blocked accumulator stage keeps both its word and the state.
    a_acc_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_vld && !w_rdy4 |=> r_s4_vld && $stable(r_acc))
        else $error("accumulator stage lost or changed a waiting word");

    // The accumulator never moves without a word entering its stage.
    a_acc_only_on_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_go4 |=> $stable(r_acc))
        else $error("accumulator changed without a word");
`endif

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking testbench for the incremental PID controller with dead band and clamp.
module testbench;
    import ipdc_pkg::*;

    localparam int ACC_W         = 48;
    localparam int SAMPLE_W      = 16;
    localparam int IN_TDATA_W    = ((2 * SAMPLE_W + 7) / 8) * 8;
    localparam int SMP_MIN       = -(2 ** (SAMPLE_W - 1));
    localparam int SMP_MAX       = 2 ** (SAMPLE_W - 1) - 1;
    localparam int ERR_MAX       = 2 ** SAMPLE_W - 1;
    localparam int SETTLE_CYCLES = 10;
    localparam int STALL_LIMIT   = 5000;
    localparam int RAND_PHASES   = 9;
    localparam int PHASE_SAMPLES = 155;

    localparam logic [GAIN_W-1:0]  GAIN_MAX  = {1'b0, {(GAIN_W - 1){1'b1}}};
    localparam logic [GAIN_W-1:0]  GAIN_MIN  = {1'b1, {(GAIN_W - 1){1'b0}}};
    localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;
    localparam logic [BAND_W-1:0]  BAND_MAX  = '1;

    // Indexes past the register set; writes to them must change nothing.
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LAST  = 3'd7;

    // One input word, setpoint in the low half.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] measured;
        logic signed [SAMPLE_W-1:0] setpoint;
    } t_ctl_sample;

    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0]     i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_data    = '0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    // Fields from bit 0 up: setpoint, measured.
    logic [IN_TDATA_W-1:0]     s_axis_tdata  = '0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    // Fields from bit 0 up: drive.
    logic [OUT_TDATA_W-1:0]    m_axis_tdata;

    incremental_pid_deadband_clamp_top #(
        .ACC_WIDTH   (ACC_W),
        .SAMPLE_WIDTH(SAMPLE_W)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // Controller state as the block should hold it.
    t_cfg                       ctl_regs   = '0;
    logic signed [ACC_W-1:0]    acc_state  = '0;
    logic signed [SAMPLE_W:0]   err_prev   = '0;
    logic signed [SAMPLE_W:0]   err_prev2  = '0;

    t_ctl_sample                pending[$];
    logic [DRIVE_W-1:0]         drive_due[$];

    int  send_gap_pct   = 0;
    int  recv_stall_pct = 0;
    logic in_taken      = 1'b0;
    int  idle_cycles    = 0;
    int  fail_count     = 0;
    int  words_in       = 0;
    int  words_out      = 0;
    int  reg_writes     = 0;
    int  sat_updates    = 0;
    int  band_zeroes    = 0;
    int  phase_count    = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Advances the controller by one sample and returns the drive it should produce.
    function automatic logic [DRIVE_W-1:0] pid_step(t_ctl_sample smp);
        longint err, band, sum, acc_next, lim, v, hi, lo;
        err      = longint'(smp.measured) - longint'(smp.setpoint);
        band     = longint'(ctl_regs.band);
        hi       = (longint'(1) <<< (ACC_W - 1)) - 1;
        lo       = -hi - 1;
        acc_next = 0;
        if (err > band || err < -band) begin
            sum = longint'(ctl_regs.k1) * err - longint'(ctl_regs.k2) * longint'(err_prev)
                + longint'(ctl_regs.k3) * longint'(err_prev2);
            acc_next = longint'(acc_state) + sum;
            if (acc_next > hi) begin
                acc_next = hi;
                sat_updates++;
            end else if (acc_next < lo) begin
                acc_next = lo;
                sat_updates++;
            end
        end else begin
            band_zeroes++;
        end
        acc_state = acc_next[ACC_W-1:0];
        err_prev2 = err_prev;
        err_prev  = err[SAMPLE_W:0];
        lim = longint'(ctl_regs.limit);
        v   = acc_next;
        if (v > lim)
            v = lim;
        if (v < -lim)
            v = -lim;
        v = v / SCALE_DIV;
        return v[DRIVE_W-1:0];
    endfunction

    // Picks a setpoint so that both samples stay in range for the wanted error.
    function automatic t_ctl_sample sample_with_error(int err);
        t_ctl_sample smp;
        int lo, hi, sp, ms;
        lo = (SMP_MIN - err > SMP_MIN) ? SMP_MIN - err : SMP_MIN;
        hi = (SMP_MAX - err < SMP_MAX) ? SMP_MAX - err : SMP_MAX;
        sp = lo + int'($urandom_range(hi - lo));
        ms = sp + err;
        smp.setpoint = sp[SAMPLE_W-1:0];
        smp.measured = ms[SAMPLE_W-1:0];
        return smp;
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(5))
            0: return GAIN_MAX;
            1: return GAIN_MIN;
            2: return '0;
            3: return GAIN_W'($signed(r[12:0]));
            default: return r[GAIN_W-1:0];
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        reg_writes++;
        case (idx)
            REG_GAIN_K1:      ctl_regs.k1    = val[GAIN_W-1:0];
            REG_GAIN_K2:      ctl_regs.k2    = val[GAIN_W-1:0];
            REG_GAIN_K3:      ctl_regs.k3    = val[GAIN_W-1:0];
            REG_OUTPUT_LIMIT: ctl_regs.limit = val[LIMIT_W-1:0];
            REG_DEAD_BAND:    ctl_regs.band  = val[BAND_W-1:0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Bits above a register's width carry random junk; the block must drop them.
    task automatic program_regs(input logic [GAIN_W-1:0] k1, input logic [GAIN_W-1:0] k2,
                                input logic [GAIN_W-1:0] k3, input logic [LIMIT_W-1:0] lim,
                                input logic [BAND_W-1:0] band);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        write_reg(REG_GAIN_K1, {junk[CFG_DATA_W-1:GAIN_W], k1});
        write_reg(REG_GAIN_K2, {junk[CFG_DATA_W-1:GAIN_W], k2});
        write_reg(REG_GAIN_K3, {junk[CFG_DATA_W-1:GAIN_W], k3});
        write_reg(REG_OUTPUT_LIMIT, lim);
        write_reg(REG_DEAD_BAND, {junk[CFG_DATA_W-1:BAND_W], band});
        end_writes();
        phase_count++;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending.size() != 0 || s_axis_tvalid || drive_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic push_pair(input int sp, input int ms);
        t_ctl_sample smp;
        smp.setpoint = sp[SAMPLE_W-1:0];
        smp.measured = ms[SAMPLE_W-1:0];
        pending.push_back(smp);
    endtask

    task automatic set_idling(input int phase);
        if (phase < 3) begin
            send_gap_pct   = 32;
            recv_stall_pct = 63;
        end else if (phase < 6) begin
            send_gap_pct   = 63;
            recv_stall_pct = 32;
        end else begin
            send_gap_pct   = 0;
            recv_stall_pct = 0;
        end
    endtask

    // Sender and receiver, both changing at the falling edge.
    always @(negedge i_clk) begin : drive_side
        t_ctl_sample next_smp;
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (pending.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                next_smp = pending.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= IN_TDATA_W'(next_smp);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Results are checked before the new word is predicted, so order within a step never matters.
    always @(posedge i_clk) begin : watch_side
        logic [DRIVE_W-1:0] due;
        logic               busy;
        if (!i_rst_n) begin
            in_taken    <= 1'b0;
            idle_cycles <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (drive_due.size() == 0) begin
                    $error("drive word with nothing expected: actual %0d",
                           $signed(m_axis_tdata[DRIVE_W-1:0]));
                    fail_count++;
                end else begin
                    due = drive_due.pop_front();
                    words_out++;
                    if (m_axis_tdata[DRIVE_W-1:0] !== due) begin
                        $error("drive mismatch: expected %0d, actual %0d",
                               $signed(due), $signed(m_axis_tdata[DRIVE_W-1:0]));
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                drive_due.push_back(pid_step(t_ctl_sample'(s_axis_tdata[2*SAMPLE_W-1:0])));
                words_in++;
            end
            in_taken <= s_axis_tvalid && s_axis_tready;
            busy = (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || i_cfg_we;
            if (busy) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        int n, r, run_len, err, phase;
        logic [63:0] rnd;
        logic [GAIN_W-1:0] k1, k2, k3;
        logic [LIMIT_W-1:0] lim;
        logic [BAND_W-1:0] band;

        set_idling(0);
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Registers still at reset: zero limit keeps the drive at zero.
        push_pair(SMP_MIN, SMP_MAX);
        push_pair(SMP_MAX, SMP_MIN);
        wait_drained();

        // Extreme gains and limit, no dead band, plus ignored writes to spare indexes.
        program_regs(GAIN_MAX, GAIN_MIN, GAIN_MAX, LIMIT_MAX, '0);
        for (int idx = REG_SPARE_FIRST; idx <= REG_SPARE_LAST; idx++) begin
            rnd = {$urandom, $urandom};
            write_reg(idx[CFG_ADDR_W-1:0], rnd[CFG_DATA_W-1:0]);
        end
        end_writes();
        push_pair(SMP_MIN, SMP_MAX);
        push_pair(SMP_MIN, SMP_MAX);
        push_pair(SMP_MAX, SMP_MIN);
        push_pair(0, 0);
        push_pair(SMP_MAX, SMP_MAX);
        push_pair(SMP_MIN, SMP_MIN);
        push_pair(1, 0);
        push_pair(0, 1);
        push_pair(SMP_MIN, 0);
        push_pair(0, SMP_MIN);
        push_pair(12345, -2222);
        wait_drained();

        // Zero limit together with errors on both edges of the dead band.
        program_regs(GAIN_W'(1024), GAIN_W'(-512), GAIN_W'(256), '0, BAND_W'(100));
        pending.push_back(sample_with_error(100));
        pending.push_back(sample_with_error(101));
        pending.push_back(sample_with_error(-100));
        pending.push_back(sample_with_error(-101));
        pending.push_back(sample_with_error(ERR_MAX));
        wait_drained();

        // Widest dead band swallows every possible error.
        program_regs(GAIN_MAX, '0, '0, LIMIT_W'(1 << 30), BAND_MAX);
        pending.push_back(sample_with_error(ERR_MAX));
        pending.push_back(sample_with_error(-ERR_MAX));
        pending.push_back(sample_with_error(0));
        wait_drained();

        for (phase = 0; phase < RAND_PHASES; phase++) begin
            set_idling(phase);
            r = $urandom_range(9);
            if (r < 2) begin
                k1 = GAIN_MAX;
                k2 = GAIN_MIN;
                k3 = GAIN_MAX;
            end else if (r < 4) begin
                k1 = GAIN_MIN;
                k2 = GAIN_MAX;
                k3 = GAIN_MIN;
            end else begin
                k1 = pick_gain();
                k2 = pick_gain();
                k3 = pick_gain();
            end
            rnd = {$urandom, $urandom};
            case ($urandom_range(5))
                0: lim = '0;
                1, 2: lim = LIMIT_MAX;
                3: lim = rnd[LIMIT_W-1:0];
                4: lim = LIMIT_W'(rnd[39:0]);
                default: lim = LIMIT_W'(rnd[19:0]);
            endcase
            case ($urandom_range(6))
                0, 1: band = '0;
                2: band = BAND_MAX;
                3: band = BAND_W'($urandom_range(ERR_MAX));
                4: band = BAND_W'(ERR_MAX);
                default: band = BAND_W'($urandom_range(300));
            endcase
            program_regs(k1, k2, k3, lim, band);

            // Long runs of one error drive the accumulator into saturation; the rest is
            // dead-band edges and fully random words.
            n = 0;
            while (n < PHASE_SAMPLES) begin
                r = $urandom_range(99);
                if (r < 40) begin
                    run_len = $urandom_range(150, 10);
                    if (run_len > PHASE_SAMPLES - n)
                        run_len = PHASE_SAMPLES - n;
                    if ($urandom_range(2) == 0)
                        err = ($urandom_range(1) == 0) ? ERR_MAX : -ERR_MAX;
                    else
                        err = int'($urandom_range(2 * ERR_MAX)) - ERR_MAX;
                    repeat (run_len) pending.push_back(sample_with_error(err));
                    n += run_len;
                end else if (r < 65) begin
                    err = int'(ctl_regs.band) + int'($urandom_range(1));
                    if (err > ERR_MAX)
                        err = ERR_MAX;
                    if ($urandom_range(1) == 0)
                        err = -err;
                    pending.push_back(sample_with_error(err));
                    n++;
                end else begin
                    pending.push_back(t_ctl_sample'($urandom));
                    n++;
                end
            end
            // The sender holds off here until every drive word has come back.
            wait_drained();
        end

        $display("summary: %0d samples sent, %0d drive words checked, %0d register writes",
                 words_in, words_out, reg_writes);
        $display("summary: %0d settings, %0d saturated updates, %0d dead-band zeroes",
                 phase_count, sat_updates, band_zeroes);
        if (fail_count == 0 && drive_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/ipdc_pkg.sv
design/ipdc_cfg.sv
design/ipdc_clamp.sv
design/incremental_pid_deadband_clamp_top.sv
verif/testbench.sv
